// File: hw/rtl/circle_grid_collision_unit_macros.svh
// ----------------------------------------------------------------------------
// circle_grid_collision_unit_macros
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef CIRCLE_GRID_COLLISION_UNIT_MACROS_SVH
`define CIRCLE_GRID_COLLISION_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg
// shared types, field widths and codes of the circle grid collision unit
// ----------------------------------------------------------------------------
package cgc_pkg;

  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;
  localparam int FRAC_BITS_DEF = 8;

  localparam int ROW_IDX_W = 5;
  localparam int ROW_WALLS_W = 32;
  localparam int COORD_W = 16;
  localparam int RADIUS_W = 9;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] USED_ROWS_RST = 6'd20;
  localparam logic [CFG_W-1:0] USED_COLS_RST = 6'd30;

  localparam logic [CFG_IDX_W-1:0] REG_USED_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USED_COLS = 2'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take_load;
    logic take_query;
    logic setup;
    logic row_start;
    logic col_next;
    logic row_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic oob;
    logic cell_hit;
    logic col_last;
    logic row_last;
  } status_t;

endpackage

// File: hw/rtl/cgc_ram.sv
// ----------------------------------------------------------------------------
// cgc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cgc_dp.sv
// ----------------------------------------------------------------------------
// cgc_dp
// datapath: wall grid store, config registers, window bounds and distance test
// ----------------------------------------------------------------------------
module cgc_dp #(
  parameter int GRID_ROWS = cgc_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = cgc_pkg::GRID_COLS_DEF,
  parameter int FRAC_BITS = cgc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgc_pkg::CFG_W-1:0]           cfg_data,
  input  logic [cgc_pkg::ROW_IDX_W-1:0]       in_row_index,
  input  logic [cgc_pkg::ROW_WALLS_W-1:0]     in_row_walls,
  input  logic signed [cgc_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [cgc_pkg::COORD_W-1:0]  in_center_z,
  input  logic [cgc_pkg::RADIUS_W-1:0]        in_radius,
  input  cgc_pkg::cmd_t                       cmd,
  output cgc_pkg::status_t                    status
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int IDX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int AW = (cgc_pkg::COORD_W + 2 > IDX_W + FRAC_BITS + 2) ?
                      cgc_pkg::COORD_W + 2 : IDX_W + FRAC_BITS + 2;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int RW = cgc_pkg::RADIUS_W;
  localparam int SQ_W = 2 * RW;
  localparam int WX_W = ROW_W + cgc_pkg::ROW_IDX_W;
  localparam int WD_W = GRID_COLS + cgc_pkg::ROW_WALLS_W;

  // distance from a coordinate to the span of cell idx, as a magnitude
  function automatic logic [RW-1:0] span_dist(input logic signed [AW-1:0] c,
                                              input logic [IDX_W-1:0] idx);
    logic signed [AW-1:0] lo;
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] d;
    lo = $signed(AW'({idx, {FRAC_BITS{1'b0}}}));
    hi = lo + AW'(ONE_I);
    if (c < lo) begin
      d = lo - c;
    end else if (c > hi) begin
      d = c - hi;
    end else begin
      d = '0;
    end
    // inside the window the gap never exceeds the radius
    return d[RW-1:0];
  endfunction

  logic [cgc_pkg::CFG_W-1:0] used_rows_r;
  logic [cgc_pkg::CFG_W-1:0] used_cols_r;

  logic signed [cgc_pkg::COORD_W-1:0] cx_r;
  logic signed [cgc_pkg::COORD_W-1:0] cz_r;
  logic [RW-1:0]                      rad_r;

  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] rmax_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] cmin_r;
  logic [COL_W-1:0] cmax_r;
  logic [SQ_W-1:0]  rr_r;
  logic [SQ_W-1:0]  dz_sq_r;
  logic             row_vld_r;
  logic [GRID_ROWS-1:0] valid_r;

  logic [GRID_COLS-1:0] row_q;
  logic                 wr_en;
  logic [WX_W-1:0]      wr_idx_ext;
  logic [WD_W-1:0]      wr_data_ext;

  logic signed [AW-1:0] cx_ext;
  logic signed [AW-1:0] cz_ext;
  logic signed [AW-1:0] rad_ext;
  logic signed [AW-1:0] cmin_f;
  logic signed [AW-1:0] cmax_f;
  logic signed [AW-1:0] rmin_f;
  logic signed [AW-1:0] rmax_f;
  logic [cgc_pkg::CFG_W:0] rows_eff;
  logic [cgc_pkg::CFG_W:0] cols_eff;
  logic signed [AW-1:0] rows_ext;
  logic signed [AW-1:0] cols_ext;

  logic [RW-1:0]   dx_mag;
  logic [RW-1:0]   dz_mag;
  logic [SQ_W-1:0] dx_sq;
  logic [SQ_W:0]   dist_sq;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_rows_r <= cgc_pkg::USED_ROWS_RST;
      used_cols_r <= cgc_pkg::USED_COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgc_pkg::REG_USED_ROWS: used_rows_r <= cfg_data;
        cgc_pkg::REG_USED_COLS: used_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // row load
  assign wr_idx_ext = WX_W'(in_row_index);
  assign wr_data_ext = WD_W'(in_row_walls);
  assign wr_en = cmd.take_load && (wr_idx_ext < WX_W'(GRID_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx_ext[ROW_W-1:0]] <= 1'b1;
    end
  end

  cgc_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx_ext[ROW_W-1:0]),
    .wdata (wr_data_ext[GRID_COLS-1:0]),
    .re    (cmd.row_start),
    .raddr (row_r),
    .q     (row_q)
  );

  // window bounds from the captured query
  assign cx_ext = AW'(cx_r);
  assign cz_ext = AW'(cz_r);
  assign rad_ext = $signed(AW'(rad_r));
  assign cmin_f = (cx_ext - rad_ext) >>> FRAC_BITS;
  assign cmax_f = (cx_ext + rad_ext) >>> FRAC_BITS;
  assign rmin_f = (cz_ext - rad_ext) >>> FRAC_BITS;
  assign rmax_f = (cz_ext + rad_ext) >>> FRAC_BITS;

  assign rows_eff = ({1'b0, used_rows_r} < (cgc_pkg::CFG_W + 1)'(GRID_ROWS)) ?
                    {1'b0, used_rows_r} : (cgc_pkg::CFG_W + 1)'(GRID_ROWS);
  assign cols_eff = ({1'b0, used_cols_r} < (cgc_pkg::CFG_W + 1)'(GRID_COLS)) ?
                    {1'b0, used_cols_r} : (cgc_pkg::CFG_W + 1)'(GRID_COLS);
  assign rows_ext = $signed(AW'(rows_eff));
  assign cols_ext = $signed(AW'(cols_eff));

  assign status.oob = (rmin_f < 0) || (rmax_f >= rows_ext) ||
                      (cmin_f < 0) || (cmax_f >= cols_ext);

  // per-cell distance test
  assign dx_mag = span_dist(cx_ext, IDX_W'(col_r));
  assign dz_mag = span_dist(cz_ext, IDX_W'(row_r));
  assign dx_sq = dx_mag * dx_mag;
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dz_sq_r};

  assign status.cell_hit = row_vld_r && row_q[col_r] && (dist_sq < {1'b0, rr_r});
  assign status.col_last = (col_r == cmax_r);
  assign status.row_last = (row_r == rmax_r);

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      cx_r <= in_center_x;
      cz_r <= in_center_z;
      rad_r <= in_radius;
    end
    if (cmd.setup) begin
      row_r <= rmin_f[ROW_W-1:0];
      rmax_r <= rmax_f[ROW_W-1:0];
      cmin_r <= cmin_f[COL_W-1:0];
      cmax_r <= cmax_f[COL_W-1:0];
      rr_r <= rad_r * rad_r;
    end
    if (cmd.row_start) begin
      col_r <= cmin_r;
      dz_sq_r <= dz_mag * dz_mag;
      row_vld_r <= valid_r[row_r];
    end
    if (cmd.col_next) begin
      col_r <= col_r + COL_W'(1);
    end
    if (cmd.row_next) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

endmodule

// File: hw/rtl/cgc_ctrl.sv
// ----------------------------------------------------------------------------
// cgc_ctrl
// controller: input handshake, window walk sequencing and result register
// ----------------------------------------------------------------------------
module cgc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  input  cgc_pkg::status_t status,
  output cgc_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_ROW   = 3'd2;
  localparam logic [2:0] ST_COL   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       res_r;
  logic       res_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_hit_r;
  logic       out_hit_nxt;
  logic       take;
  logic       slot_free;

  assign in_stall = (state_r != ST_IDLE);
  assign take = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt = out_hit_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_op == cgc_pkg::OP_QUERY) begin
            cmd.take_query = 1'b1;
            state_nxt = ST_SETUP;
          end else begin
            cmd.take_load = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (status.oob) begin
          res_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_start = 1'b1;
        state_nxt = ST_COL;
      end
      ST_COL: begin
        priority if (status.cell_hit) begin
          res_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (!status.col_last) begin
          cmd.col_next = 1'b1;
        end else if (!status.row_last) begin
          cmd.row_next = 1'b1;
          state_nxt = ST_ROW;
        end else begin
          res_nxt = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_hit_r <= out_hit_nxt;
  end

endmodule

// File: hw/rtl/circle_grid_collision_unit.sv
// ----------------------------------------------------------------------------
// circle_grid_collision_unit
// circle against occupancy grid collision test with row-wise grid loading
// ----------------------------------------------------------------------------
// A load transaction writes one grid row and the input is ready again right
// after. A query transaction walks the covered cell window one row read and
// then one cell per cycle; the walk stops at the first wall cell found within
// the radius, and a window that leaves the used grid answers straight from
// the setup step without a walk. With 8 fraction bits the window is at most
// 5 by 5 cells. The walk speed is set by the single read port of the grid ram
// and the one squared-distance test per cycle. A finished result waits in an
// output register while the next transaction is accepted. The grid reads as
// all clear after reset.
module circle_grid_collision_unit #(
  parameter int GRID_ROWS = cgc_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = cgc_pkg::GRID_COLS_DEF,
  parameter int FRAC_BITS = cgc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [cgc_pkg::ROW_IDX_W-1:0]       in_row_index,
  input  logic [cgc_pkg::ROW_WALLS_W-1:0]     in_row_walls,
  input  logic signed [cgc_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [cgc_pkg::COORD_W-1:0]  in_center_z,
  input  logic [cgc_pkg::RADIUS_W-1:0]        in_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit
);

  cgc_pkg::cmd_t    cmd;
  cgc_pkg::status_t status;

  cgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit),
    .status    (status),
    .cmd       (cmd)
  );

  cgc_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_row_index (in_row_index),
    .in_row_walls (in_row_walls),
    .in_center_x  (in_center_x),
    .in_center_z  (in_center_z),
    .in_radius    (in_radius),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// File: hw/rtl/cgc_checker.sv
// ----------------------------------------------------------------------------
// cgc_checker
// port-level checks of the circle grid collision unit, bound to the top level
// ----------------------------------------------------------------------------
`include "circle_grid_collision_unit_macros.svh"

module cgc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_op,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  // a held result keeps its value
  `CGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hit), "result changed while stalled")

  // a query transaction occupies the block for at least the next cycle
  `CGC_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && (in_op == cgc_pkg::OP_QUERY), in_stall, "input not stalled after a query")

  // a row load finishes in the cycle it is taken
  `CGC_ASSERT_NEXT(a_load_free, clk, rst_n, in_valid && !in_stall && (in_op == cgc_pkg::OP_LOAD), !in_stall, "input stalled after a row load")

  // a result only appears at the end of a query
  `CGC_ASSERT_NOW(a_result_src, clk, rst_n, $rose(out_valid), $past(in_stall), "result without a query in progress")

endmodule

bind circle_grid_collision_unit cgc_checker u_cgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_hit   (out_hit)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the circle grid collision unit: directed grid loads
// and circle queries, then random transactions over several used-grid sizes,
// each query checked against a typed value or a cycle-free model of the grid
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cgc_pkg::*;

  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam longint CELL         = longint'(1) << FRAC;
  localparam int     RANDOM_ITEMS = 1450;
  localparam int     PHASE_COUNT  = 10;
  localparam int     PHASE_ITEMS  = RANDOM_ITEMS / PHASE_COUNT;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     QUIET_LIMIT  = 3000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_op;
  logic [ROW_IDX_W-1:0]       in_row_index;
  logic [ROW_WALLS_W-1:0]     in_row_walls;
  logic signed [COORD_W-1:0]  in_center_x;
  logic signed [COORD_W-1:0]  in_center_z;
  logic [RADIUS_W-1:0]        in_radius;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_hit;

  // expected value typed into the table, travels with the transaction
  bit pin_valid;
  bit pin_hit;

  // model of the block state
  logic [ROW_WALLS_W-1:0] wall_rows_q [GRID_ROWS_DEF];
  logic [CFG_W-1:0]       used_rows_q;
  logic [CFG_W-1:0]       used_cols_q;

  bit expected_hits [$];
  int mismatches;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  typedef struct {
    logic                      op;
    logic [ROW_IDX_W-1:0]      row;
    logic [ROW_WALLS_W-1:0]    walls;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic [RADIUS_W-1:0]       r;
    bit                        pinned;
    bit                        pin_val;
  } plan_row_t;

  plan_row_t plan [$];

  int phase_rows [PHASE_COUNT] = '{32, 1, 0, 20, 63, 32, 2, 17, -1, -1};
  int phase_cols [PHASE_COUNT] = '{32, 1, 20, 0, 63, 1, 32, 23, -1, -1};

  circle_grid_collision_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row_index (in_row_index),
    .in_row_walls (in_row_walls),
    .in_center_x  (in_center_x),
    .in_center_z  (in_center_z),
    .in_radius    (in_radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit hit_for_circle(logic signed [COORD_W-1:0] cx_in,
                                        logic signed [COORD_W-1:0] cz_in,
                                        logic [RADIUS_W-1:0] r_in);
    longint cx, cz, rad, rows, cols, cmin, cmax, rmin, rmax;
    longint row, col, qx, qz, dx, dz;
    cx = cx_in;
    cz = cz_in;
    rad = r_in;
    rows = (used_rows_q < GRID_ROWS_DEF) ? used_rows_q : GRID_ROWS_DEF;
    cols = (used_cols_q < GRID_COLS_DEF) ? used_cols_q : GRID_COLS_DEF;
    // arithmetic shift gives floor for negative coordinates
    cmin = (cx - rad) >>> FRAC;
    cmax = (cx + rad) >>> FRAC;
    rmin = (cz - rad) >>> FRAC;
    rmax = (cz + rad) >>> FRAC;
    if (rmin < 0 || rmax >= rows || cmin < 0 || cmax >= cols)
      return 1'b1;
    for (row = rmin; row <= rmax; row++) begin
      for (col = cmin; col <= cmax; col++) begin
        if (wall_rows_q[row][col]) begin
          qx = (cx < col * CELL) ? col * CELL :
               (cx > (col + 1) * CELL) ? (col + 1) * CELL : cx;
          qz = (cz < row * CELL) ? row * CELL :
               (cz > (row + 1) * CELL) ? (row + 1) * CELL : cz;
          dx = cx - qx;
          dz = cz - qz;
          if (dx * dx + dz * dz < rad * rad)
            return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic report_bad(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  // scoreboard: model update per accepted transaction, check per taken result
  always @(posedge clk) begin : watch
    bit want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_USED_ROWS: used_rows_q = cfg_data;
          REG_USED_COLS: used_cols_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_hits.size() == 0) begin
          report_bad($sformatf("unexpected result transaction, hit=%0d", out_hit));
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want)
            report_bad($sformatf("hit mismatch: expected %0d, got %0d", want, out_hit));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (in_op == OP_LOAD) begin
          wall_rows_q[in_row_index] = in_row_walls;
        end else begin
          want = pin_valid ? pin_hit : hit_for_circle(in_center_x, in_center_z, in_radius);
          expected_hits.push_back(want);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // entered and left at a falling edge, valid stays high for a follow-on
  task automatic send_item(logic op, logic [ROW_IDX_W-1:0] row,
                           logic [ROW_WALLS_W-1:0] walls,
                           logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cz,
                           logic [RADIUS_W-1:0] r, bit pinned, bit pin_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op        <= op;
    in_row_index <= row;
    in_row_walls <= walls;
    in_center_x  <= cx;
    in_center_z  <= cz;
    in_radius    <= r;
    pin_valid    <= pinned;
    pin_hit      <= pin_val;
    in_valid     <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall)
        break;
    end
    @(negedge clk);
  endtask

  task automatic plan_add(logic op, logic [ROW_IDX_W-1:0] row,
                          logic [ROW_WALLS_W-1:0] walls, int cx, int cz, int r,
                          bit pinned, bit pin_val);
    plan_row_t p;
    p.op      = op;
    p.row     = row;
    p.walls   = walls;
    p.cx      = cx[COORD_W-1:0];
    p.cz      = cz[COORD_W-1:0];
    p.r       = r[RADIUS_W-1:0];
    p.pinned  = pinned;
    p.pin_val = pin_val;
    plan.push_back(p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // wait until the block is idle, then change the used grid size
  task automatic resize_grid(int rows, int cols);
    in_valid <= 1'b0;
    while (expected_hits.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_USED_ROWS, (rows < 0) ? $urandom_range(0, 63) : rows);
    write_reg(REG_SPARE_HI, $urandom);
    write_reg(REG_USED_COLS, (cols < 0) ? $urandom_range(0, 63) : cols);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    int pick, lim_c, lim_r, cx, cz, r;
    logic [ROW_WALLS_W-1:0] walls;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0: walls = $urandom;
        1: walls = $urandom & $urandom & $urandom;
        2: walls = '0;
        default: walls = 32'd1 << $urandom_range(0, 31);
      endcase
      send_item(OP_LOAD, $urandom_range(0, 31), walls, $urandom, $urandom, $urandom, 0, 0);
    end else if (pick < 88) begin
      // centre around the used grid, including a cell margin on each side
      lim_c = (used_cols_q > GRID_COLS_DEF) ? GRID_COLS_DEF : used_cols_q;
      lim_r = (used_rows_q > GRID_ROWS_DEF) ? GRID_ROWS_DEF : used_rows_q;
      cx = int'($urandom_range(0, (lim_c + 2) * CELL)) - int'(CELL);
      cz = int'($urandom_range(0, (lim_r + 2) * CELL)) - int'(CELL);
      if ($urandom_range(0, 3) == 0) begin
        cx = cx & ~127;
        cz = cz & ~127;
      end
      case ($urandom_range(0, 3))
        0: r = 0;
        1: r = $urandom_range(0, 300);
        2: r = 128 * $urandom_range(0, 3);
        default: r = $urandom_range(0, 511);
      endcase
      send_item(OP_QUERY, $urandom, $urandom, cx[COORD_W-1:0], cz[COORD_W-1:0],
                r[RADIUS_W-1:0], 0, 0);
    end else begin
      send_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
    end
  endtask

  initial begin : stimulus
    int i, k, ph;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_USED_ROWS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_op        = OP_LOAD;
    in_row_index = '0;
    in_row_walls = '0;
    in_center_x  = '0;
    in_center_z  = '0;
    in_radius    = '0;
    pin_valid    = 1'b0;
    pin_hit      = 1'b0;
    hold_req     = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    used_rows_q  = USED_ROWS_RST;
    used_cols_q  = USED_COLS_RST;
    foreach (wall_rows_q[k])
      wall_rows_q[k] = '0;
    send_idle_pct = 28;
    recv_idle_pct = 54;

    // after reset: 20 rows, 30 columns, empty grid
    plan_add(OP_QUERY, 0, 0, 1408, 1408, 256, 1, 0);
    plan_add(OP_QUERY, 0, 0, 0, 0, 0, 1, 0);
    plan_add(OP_QUERY, 0, 0, -32768, 0, 0, 1, 1);
    plan_add(OP_QUERY, 0, 0, 32767, 32767, 511, 1, 1);
    // right edge lands exactly on the first unused column
    plan_add(OP_QUERY, 0, 0, 7552, 1408, 128, 1, 1);
    plan_add(OP_QUERY, 0, 0, 7551, 1408, 128, 1, 0);
    // just below zero floors to cell -1
    plan_add(OP_QUERY, 0, 0, -1, 1408, 0, 1, 1);
    plan_add(OP_QUERY, 0, 0, 1408, 5119, 0, 1, 0);
    plan_add(OP_QUERY, 0, 0, 1408, 5120, 0, 1, 1);
    plan_add(OP_LOAD, 5, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    plan_add(OP_LOAD, 0, 32'h0000_0000, 0, 0, 0, 0, 0);
    plan_add(OP_LOAD, 31, 32'h8000_0001, -32768, 32767, 511, 0, 0);
    plan_add(OP_LOAD, 6, 32'h0000_0010, 0, 0, 0, 0, 0);
    // wall square exactly at the radius, then just inside it
    plan_add(OP_QUERY, 0, 0, 1408, 1152, 128, 0, 0);
    plan_add(OP_QUERY, 0, 0, 1408, 1152, 129, 0, 0);
    // centre inside a wall with zero radius
    plan_add(OP_QUERY, 0, 0, 1408, 1408, 0, 1, 0);
    plan_add(OP_QUERY, 0, 0, 1408, 1408, 511, 0, 0);
    plan_add(OP_QUERY, 0, 0, 896, 1664, 200, 0, 0);
    // diagonal distance to a wall corner
    plan_add(OP_QUERY, 0, 0, 1408, 1920, 182, 0, 0);
    plan_add(OP_QUERY, 0, 0, 1408, 1920, 181, 0, 0);
    plan_add(OP_LOAD, 5, 32'h0000_0000, 32767, -32768, 511, 0, 0);
    plan_add(OP_QUERY, 31, 32'hFFFF_FFFF, 1408, 1152, 129, 0, 0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k])
      send_item(plan[k].op, plan[k].row, plan[k].walls, plan[k].cx, plan[k].cz,
                plan[k].r, plan[k].pinned, plan[k].pin_val);

    ph = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0 && ph < PHASE_COUNT) begin
        resize_grid(phase_rows[ph], phase_cols[ph]);
        ph++;
      end
      if (i < RANDOM_ITEMS / 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 54;
      end else if (i < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold-off while transactions keep coming
      if (i == 200)
        hold_req = 1'b1;
      // sender pauses until the pipeline is empty
      if (i == 700) begin
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
          @(negedge clk);
        @(negedge clk);
      end
      send_random();
    end

    in_valid <= 1'b0;
    while (expected_hits.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cgc_pkg.sv
hw/rtl/cgc_ram.sv
hw/rtl/cgc_dp.sv
hw/rtl/cgc_ctrl.sv
hw/rtl/circle_grid_collision_unit.sv
hw/rtl/cgc_checker.sv
dv/testbench.sv
